// ===== hw/rtl/apr_pkg.sv =====
package apr_pkg;

	localparam int MAX_FRAMES_DEF = 128;
	localparam int PAGE_COUNT_DEF = 128;
	localparam int AGE_BITS_DEF = 12;

	localparam int PAGE_W = 7;
	localparam int FRAME_W = 7;
	localparam int COUNT_W = 32;
	localparam int ELAPSED_W = 17;
	localparam int FIU_W = 8;
	localparam int PERIOD_W = 16;
	localparam int COST_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	localparam logic [FIU_W-1:0] FRAMES_IN_USE_RST = 8'd100;
	localparam logic [PERIOD_W-1:0] SHIFT_PERIOD_RST = 16'd8;
	localparam logic [COST_W-1:0] HIT_COST_RST = 8'd10;
	localparam logic [COST_W-1:0] MISS_COST_RST = 8'd50;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAMES_IN_USE = 2'd0,
		CFG_SHIFT_PERIOD = 2'd1,
		CFG_HIT_COST = 2'd2,
		CFG_MISS_COST = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page_number;
		logic last_in_run;
	} in_t;

	typedef struct packed {
		logic fault;
		logic [FRAME_W-1:0] frame_index;
		logic evicted_valid;
		logic [PAGE_W-1:0] evicted_page;
		logic [COUNT_W-1:0] fault_total;
	} out_t;

	// request to the age unit: run one pass over all frames
	typedef struct packed {
		logic start;
		logic shift;
	} age_cmd_t;

endpackage

// ===== hw/rtl/apr_ages.sv =====
module apr_ages #(
	parameter int MAX_FRAMES = apr_pkg::MAX_FRAMES_DEF,
	parameter int AGE_BITS = apr_pkg::AGE_BITS_DEF,
	localparam int FW = $clog2(MAX_FRAMES),
	localparam int CAPW = $clog2(MAX_FRAMES + 1)
) (
	input logic clk,
	input logic arst_n,
	input apr_pkg::age_cmd_t cmd,
	input logic [CAPW-1:0] cap,
	input logic wr_en,
	input logic [FW-1:0] wr_addr,
	input logic [AGE_BITS-1:0] wr_data,
	input logic [FW-1:0] rd_addr,
	output logic [AGE_BITS-1:0] rd_data,
	output logic done,
	output logic [FW-1:0] min_frame
);

	logic [AGE_BITS-1:0] mem [MAX_FRAMES];
	logic [AGE_BITS-1:0] rd_q;
	logic [FW-1:0] mem_raddr;
	logic [AGE_BITS-1:0] aged;

	logic sweep_q;
	logic shift_q;
	logic [FW-1:0] idx_q;
	logic valid_s1;
	logic [FW-1:0] idx_s1;
	logic done_q;
	logic [AGE_BITS-1:0] best_q;
	logic [FW-1:0] min_q;

	assign mem_raddr = sweep_q ? idx_q : rd_addr;
	assign aged = shift_q ? (rd_q >> 1) : rd_q;
	assign rd_data = rd_q;
	assign done = done_q;
	assign min_frame = min_q;

	always_ff @(posedge clk) begin
		if (valid_s1 && shift_q) begin
			mem[idx_s1] <= aged;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[mem_raddr];
	end

	// read runs one entry ahead of the compare and write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= 1'b0;
			shift_q <= 1'b0;
			idx_q <= '0;
			valid_s1 <= 1'b0;
			idx_s1 <= '0;
			done_q <= 1'b0;
		end else begin
			valid_s1 <= sweep_q;
			idx_s1 <= idx_q;
			done_q <= valid_s1 && (idx_s1 == FW'(MAX_FRAMES - 1));
			if (cmd.start) begin
				sweep_q <= 1'b1;
				shift_q <= cmd.shift;
				idx_q <= '0;
			end else if (sweep_q) begin
				if (idx_q == FW'(MAX_FRAMES - 1)) begin
					sweep_q <= 1'b0;
				end else begin
					idx_q <= idx_q + FW'(1);
				end
			end
		end
	end

	// lowest age among frames below cap, first index wins ties
	always_ff @(posedge clk) begin
		if (valid_s1 && (CAPW'(idx_s1) < cap)) begin
			if ((idx_s1 == '0) || (aged < best_q)) begin
				best_q <= aged;
				min_q <= idx_s1;
			end
		end
	end

endmodule

// ===== hw/rtl/aging_page_replacement_top.sv =====
// Aging page replacement engine.
// in channel (in_valid/in_ready/in_data) takes one page reference per transfer;
// out channel (out_valid/out_ready/out_data) returns exactly one result per
// reference: fault flag, frame now holding the page, evicted page and the
// running fault count. cfg_wr_en/cfg_index/cfg_wr_data write the frame count,
// shift period, hit cost and miss cost; write them only while the block is idle.
// A reference passes the page wrap, the map lookup, the update and the write
// of the hit, fill or eviction before its result is registered. When the ages
// must be shifted or a victim found, one pass of the age unit over all
// MAX_FRAMES entries comes between lookup and update; the age unit reads one
// frame per cycle. Page numbers at or above PAGE_COUNT are wrapped by repeated
// subtraction of PAGE_COUNT. An eviction reads the victim's old page before the
// fill. One reference is in work at a time; the next transfer is taken in the
// cycle after the result is registered, unless the reference ended a run.
// Reset and every reference marked last_in_run start a clearing pass over
// max(PAGE_COUNT, MAX_FRAMES) entries of the maps and ages, during which
// in_ready is low; configuration writes are taken throughout.
// The result sits in an output register; the next reference is taken while it
// waits, and a stalled receiver only holds the following result back.
module aging_page_replacement_top #(
	parameter int MAX_FRAMES = apr_pkg::MAX_FRAMES_DEF,
	parameter int PAGE_COUNT = apr_pkg::PAGE_COUNT_DEF,
	parameter int AGE_BITS = apr_pkg::AGE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input apr_pkg::in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output apr_pkg::out_t out_data,
	input logic cfg_wr_en,
	input logic [apr_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [apr_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

	localparam int FW = $clog2(MAX_FRAMES);
	localparam int CAPW = $clog2(MAX_FRAMES + 1);
	localparam int PGW = $clog2(PAGE_COUNT);
	localparam int PQW = (PGW + 1 > apr_pkg::PAGE_W) ? PGW + 1 : apr_pkg::PAGE_W;
	localparam int CW = (CAPW > apr_pkg::FIU_W) ? CAPW : apr_pkg::FIU_W;
	localparam int CLR_DEPTH = (PAGE_COUNT > MAX_FRAMES) ? PAGE_COUNT : MAX_FRAMES;
	localparam int CLRW = $clog2(CLR_DEPTH) + 1;
	localparam int EW = apr_pkg::ELAPSED_W;
	localparam int ESW = EW + 1;
	localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS - 1){1'b0}}};

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_WRAP,
		S_LOOK,
		S_SWEEP,
		S_UPD,
		S_HITW,
		S_EVICT,
		S_FILL,
		S_DONE
	} state_t;

	// configuration
	logic [apr_pkg::FIU_W-1:0] fiu_q;
	logic [apr_pkg::PERIOD_W-1:0] period_q;
	logic [apr_pkg::COST_W-1:0] hit_cost_q;
	logic [apr_pkg::COST_W-1:0] miss_cost_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q <= apr_pkg::FRAMES_IN_USE_RST;
			period_q <= apr_pkg::SHIFT_PERIOD_RST;
			hit_cost_q <= apr_pkg::HIT_COST_RST;
			miss_cost_q <= apr_pkg::MISS_COST_RST;
		end else if (cfg_wr_en) begin
			unique case (apr_pkg::cfg_idx_t'(cfg_index))
				apr_pkg::CFG_FRAMES_IN_USE: fiu_q <= cfg_wr_data[apr_pkg::FIU_W-1:0];
				apr_pkg::CFG_SHIFT_PERIOD: period_q <= cfg_wr_data[apr_pkg::PERIOD_W-1:0];
				apr_pkg::CFG_HIT_COST: hit_cost_q <= cfg_wr_data[apr_pkg::COST_W-1:0];
				apr_pkg::CFG_MISS_COST: miss_cost_q <= cfg_wr_data[apr_pkg::COST_W-1:0];
			endcase
		end
	end

	// frame count clamped to 1..MAX_FRAMES
	logic [CW-1:0] fiu_ext;
	logic [CAPW-1:0] cap_c;

	always_comb begin
		fiu_ext = CW'(fiu_q);
		priority if (fiu_ext == '0) begin
			cap_c = CAPW'(1);
		end else if (fiu_ext > CW'(MAX_FRAMES)) begin
			cap_c = CAPW'(MAX_FRAMES);
		end else begin
			cap_c = CAPW'(fiu_ext);
		end
	end

	state_t state_q;
	logic [PQW-1:0] page_q;
	logic last_q;
	logic hit_q;
	logic shift_q;
	logic [FW-1:0] frame_q;
	logic [CAPW-1:0] filled_q;
	logic [EW-1:0] elapsed_q;
	logic [apr_pkg::COUNT_W-1:0] fcnt_q;
	logic ev_valid_q;
	logic [PGW-1:0] ev_page_q;
	logic [CLRW-1:0] clr_q;
	logic out_valid_q;
	apr_pkg::out_t out_q;
	apr_pkg::age_cmd_t age_cmd_q;

	logic [PGW-1:0] page_idx;
	logic full_c;
	logic [ESW-1:0] hit_sum;
	logic [ESW-1:0] miss_sum;
	logic [EW-1:0] elapsed_hit;
	logic [EW-1:0] elapsed_miss;

	assign page_idx = page_q[PGW-1:0];
	assign full_c = (filled_q >= cap_c);
	assign hit_sum = {1'b0, elapsed_q} + ESW'(hit_cost_q);
	assign miss_sum = {1'b0, elapsed_q} + ESW'(miss_cost_q);
	assign elapsed_hit = hit_sum[EW] ? apr_pkg::ELAPSED_MAX : hit_sum[EW-1:0];
	assign elapsed_miss = miss_sum[EW] ? apr_pkg::ELAPSED_MAX : miss_sum[EW-1:0];

	// page-to-frame and frame-to-page maps, entry = {valid, value}
	logic [FW:0] p2f_mem [PAGE_COUNT];
	logic [FW:0] p2f_rd_q;
	logic p2f_we;
	logic [PGW-1:0] p2f_waddr;
	logic [FW:0] p2f_wdata;

	logic [PGW:0] f2p_mem [MAX_FRAMES];
	logic [PGW:0] f2p_rd_q;
	logic f2p_we;
	logic [FW-1:0] f2p_waddr;
	logic [PGW:0] f2p_wdata;

	logic age_we;
	logic [FW-1:0] age_waddr;
	logic [AGE_BITS-1:0] age_wdata;
	logic [AGE_BITS-1:0] age_rd;
	logic age_done;
	logic [FW-1:0] min_frame;

	// age pass needed for a shift or a victim search
	logic sweep_req_c;

	assign sweep_req_c = shift_q || (!p2f_rd_q[FW] && full_c);

	always_comb begin
		p2f_we = 1'b0;
		p2f_waddr = page_idx;
		p2f_wdata = '0;
		f2p_we = 1'b0;
		f2p_waddr = frame_q;
		f2p_wdata = '0;
		age_we = 1'b0;
		age_waddr = frame_q;
		age_wdata = AGE_TOP;
		unique case (state_q)
			S_CLEAR: begin
				p2f_we = (clr_q < CLRW'(PAGE_COUNT));
				p2f_waddr = clr_q[PGW-1:0];
				f2p_we = (clr_q < CLRW'(MAX_FRAMES));
				f2p_waddr = clr_q[FW-1:0];
				age_we = (clr_q < CLRW'(MAX_FRAMES));
				age_waddr = clr_q[FW-1:0];
				age_wdata = '0;
			end
			S_EVICT: begin
				p2f_we = f2p_rd_q[PGW];
				p2f_waddr = f2p_rd_q[PGW-1:0];
			end
			S_HITW: begin
				age_we = 1'b1;
				age_wdata = age_rd | AGE_TOP;
			end
			S_FILL: begin
				p2f_we = 1'b1;
				p2f_wdata = {1'b1, frame_q};
				f2p_we = 1'b1;
				f2p_wdata = {1'b1, page_idx};
				age_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (p2f_we) begin
			p2f_mem[p2f_waddr] <= p2f_wdata;
		end
		p2f_rd_q <= p2f_mem[page_idx];
	end

	always_ff @(posedge clk) begin
		if (f2p_we) begin
			f2p_mem[f2p_waddr] <= f2p_wdata;
		end
		f2p_rd_q <= f2p_mem[frame_q];
	end

	apr_ages #(
		.MAX_FRAMES(MAX_FRAMES),
		.AGE_BITS(AGE_BITS)
	) u_ages (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(age_cmd_q),
		.cap(cap_c),
		.wr_en(age_we),
		.wr_addr(age_waddr),
		.wr_data(age_wdata),
		.rd_addr(frame_q),
		.rd_data(age_rd),
		.done(age_done),
		.min_frame(min_frame)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			filled_q <= '0;
			elapsed_q <= '0;
			fcnt_q <= '0;
			out_valid_q <= 1'b0;
			age_cmd_q <= '0;
		end else begin
			age_cmd_q.start <= (state_q == S_LOOK) && sweep_req_c;
			age_cmd_q.shift <= shift_q;
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CLRW'(1);
					if (clr_q == CLRW'(CLR_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						page_q <= PQW'(in_data.page_number);
						last_q <= in_data.last_in_run;
						state_q <= S_WRAP;
					end
				end
				S_WRAP: begin
					if (page_q >= PQW'(PAGE_COUNT)) begin
						page_q <= page_q - PQW'(PAGE_COUNT);
					end else begin
						shift_q <= (elapsed_q >= EW'(period_q));
						if (elapsed_q >= EW'(period_q)) begin
							elapsed_q <= elapsed_q - EW'(period_q);
						end
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					hit_q <= p2f_rd_q[FW];
					frame_q <= p2f_rd_q[FW-1:0];
					ev_valid_q <= 1'b0;
					ev_page_q <= '0;
					if (sweep_req_c) begin
						state_q <= S_SWEEP;
					end else begin
						state_q <= S_UPD;
					end
				end
				S_SWEEP: begin
					if (age_done) begin
						if (!hit_q && full_c) begin
							frame_q <= min_frame;
						end
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					priority if (hit_q) begin
						state_q <= S_HITW;
					end else if (!full_c) begin
						frame_q <= filled_q[FW-1:0];
						filled_q <= filled_q + CAPW'(1);
						state_q <= S_FILL;
					end else begin
						state_q <= S_EVICT;
					end
				end
				S_HITW: begin
					elapsed_q <= elapsed_hit;
					state_q <= S_DONE;
				end
				S_EVICT: begin
					// victim's old page loses its mapping
					ev_valid_q <= f2p_rd_q[PGW];
					ev_page_q <= f2p_rd_q[PGW-1:0];
					state_q <= S_FILL;
				end
				S_FILL: begin
					if (fcnt_q != '1) begin
						fcnt_q <= fcnt_q + apr_pkg::COUNT_W'(1);
					end
					elapsed_q <= elapsed_miss;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q.fault <= !hit_q;
						out_q.frame_index <= apr_pkg::FRAME_W'(frame_q);
						out_q.evicted_valid <= ev_valid_q;
						out_q.evicted_page <= apr_pkg::PAGE_W'(ev_page_q);
						out_q.fault_total <= fcnt_q;
						if (last_q) begin
							clr_q <= '0;
							filled_q <= '0;
							elapsed_q <= '0;
							fcnt_q <= '0;
							state_q <= S_CLEAR;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_CLEAR;
					clr_q <= '0;
				end
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// ===== sim/aging_page_replacement_top_tb.sv =====
module aging_page_replacement_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import apr_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int LIMIT_CYCLES = 4_000_000;
	localparam logic [AGE_BITS_DEF-1:0] AGE_TOP = {1'b1, {(AGE_BITS_DEF - 1){1'b0}}};

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_MOSTLY,
		RX_RARELY,
		RX_WINDOW
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

	// shadow of the configuration registers
	int frames_cfg = int'(FRAMES_IN_USE_RST);
	int period_cfg = int'(SHIFT_PERIOD_RST);
	int hit_cfg = int'(HIT_COST_RST);
	int miss_cfg = int'(MISS_COST_RST);

	// predicted replacement state
	logic [AGE_BITS_DEF-1:0] frame_age [MAX_FRAMES_DEF];
	logic page_resident [PAGE_COUNT_DEF];
	logic [FRAME_W-1:0] page_frame [PAGE_COUNT_DEF];
	logic frame_used [MAX_FRAMES_DEF];
	logic [PAGE_W-1:0] frame_page [MAX_FRAMES_DEF];
	int fill_count;
	int elapsed_units;
	logic [COUNT_W-1:0] fault_count;

	in_t ref_queue [$];
	out_t predicted_lookups [$];
	int mismatches = 0;
	int cycle_count = 0;
	int burst_left = 1;
	int gap_left = 0;
	rx_mode_t rx_mode = RX_ALWAYS;
	int rx_hold = 0;

	aging_page_replacement_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wr_data(cfg_wr_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic void clear_run_state();
		foreach (frame_age[i]) begin
			frame_age[i] = '0;
			frame_used[i] = 1'b0;
			frame_page[i] = '0;
		end
		foreach (page_resident[i]) begin
			page_resident[i] = 1'b0;
			page_frame[i] = '0;
		end
		fill_count = 0;
		elapsed_units = 0;
		fault_count = '0;
	endfunction

	function automatic out_t replace_page(in_t req);
		out_t res;
		int cap;
		int frame;
		int cost;
		logic [AGE_BITS_DEF-1:0] best;
		res = '0;
		cap = (frames_cfg == 0) ? 1 :
			((frames_cfg > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : frames_cfg);
		if (elapsed_units >= period_cfg) begin
			elapsed_units -= period_cfg;
			foreach (frame_age[i]) frame_age[i] = frame_age[i] >> 1;
		end
		if (page_resident[req.page_number]) begin
			frame = int'(page_frame[req.page_number]);
			frame_age[frame] = frame_age[frame] | AGE_TOP;
			cost = hit_cfg;
		end else begin
			res.fault = 1'b1;
			if (fill_count < cap) begin
				frame = fill_count;
				fill_count++;
			end else begin
				// lowest age wins, lowest index on ties
				frame = 0;
				best = frame_age[0];
				for (int i = 1; i < cap; i++) begin
					if (frame_age[i] < best) begin
						best = frame_age[i];
						frame = i;
					end
				end
				if (frame_used[frame]) begin
					page_resident[frame_page[frame]] = 1'b0;
					page_frame[frame_page[frame]] = '0;
					res.evicted_valid = 1'b1;
					res.evicted_page = frame_page[frame];
				end
			end
			frame_used[frame] = 1'b1;
			frame_page[frame] = req.page_number;
			page_resident[req.page_number] = 1'b1;
			page_frame[req.page_number] = FRAME_W'(frame);
			frame_age[frame] = AGE_TOP;
			if (fault_count != '1) fault_count++;
			cost = miss_cfg;
		end
		elapsed_units += cost;
		if (elapsed_units > int'(ELAPSED_MAX)) elapsed_units = int'(ELAPSED_MAX);
		res.frame_index = FRAME_W'(frame);
		res.fault_total = fault_count;
		if (req.last_in_run) clear_run_state();
		return res;
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_FRAMES_IN_USE: frames_cfg = int'(value[FIU_W-1:0]);
			CFG_SHIFT_PERIOD: period_cfg = int'(value[PERIOD_W-1:0]);
			CFG_HIT_COST: hit_cfg = int'(value[COST_W-1:0]);
			CFG_MISS_COST: miss_cfg = int'(value[COST_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic push_ref(int page, bit last);
		in_t item;
		item.page_number = PAGE_W'(page);
		item.last_in_run = last;
		ref_queue.push_back(item);
	endtask

	// sender pauses here until every predicted lookup has come back
	task automatic drain();
		do @(negedge clk);
		while (ref_queue.size() != 0 || in_valid || predicted_lookups.size() != 0);
	endtask

	// driver: bursts of random length with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) predicted_lookups.push_back(replace_page(in_data));
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (ref_queue.size() != 0) begin
					in_valid <= 1'b1;
					in_data <= ref_queue.pop_front();
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200)
							: $urandom_range(0, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (rx_hold == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_hold = $urandom_range(50, 400);
		end else begin
			rx_hold--;
		end
		case (rx_mode)
			RX_ALWAYS: out_ready <= 1'b1;
			RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
			RX_RARELY: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (cycle_count % 256) > 200;
		endcase
	end

	// monitor: every result transfer against the oldest prediction
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (predicted_lookups.size() == 0) begin
				$error("result with no prediction pending: %h", out_data);
				mismatches++;
			end else begin
				want = predicted_lookups.pop_front();
				if (out_data.fault !== want.fault) begin
					$error("fault: expected %0d, actual %0d", want.fault, out_data.fault);
					mismatches++;
				end
				if (out_data.frame_index !== want.frame_index) begin
					$error("frame_index: expected %0d, actual %0d",
						want.frame_index, out_data.frame_index);
					mismatches++;
				end
				if (out_data.evicted_valid !== want.evicted_valid) begin
					$error("evicted_valid: expected %0d, actual %0d",
						want.evicted_valid, out_data.evicted_valid);
					mismatches++;
				end
				if (out_data.evicted_page !== want.evicted_page) begin
					$error("evicted_page: expected %0d, actual %0d",
						want.evicted_page, out_data.evicted_page);
					mismatches++;
				end
				if (out_data.fault_total !== want.fault_total) begin
					$error("fault_total: expected %0d, actual %0d",
						want.fault_total, out_data.fault_total);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("aging_page_replacement_top_tb failed");
			$finish;
		end
	end

	initial begin
		int frames;
		int period;
		int hit;
		int miss;
		int count;
		int cap;
		int window;
		int base;
		int page;
		bit last;
		clear_run_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: fill, hit, highest page, end of run
		@(negedge clk);
		push_ref(0, 0);
		push_ref(0, 0);
		push_ref(127, 0);
		push_ref(127, 1);
		drain();

		// frame count zero acts as one, shift before every reference
		write_reg(CFG_FRAMES_IN_USE, 16'd0);
		write_reg(CFG_SHIFT_PERIOD, 16'd0);
		write_reg(CFG_HIT_COST, 16'd0);
		write_reg(CFG_MISS_COST, 16'd255);
		@(negedge clk);
		push_ref(5, 0);
		push_ref(5, 0);
		push_ref(9, 0);
		push_ref(5, 0);
		push_ref(9, 1);
		drain();

		// equal ages, longest period; upper data bits are ignored
		write_reg(CFG_FRAMES_IN_USE, 16'd2);
		write_reg(CFG_SHIFT_PERIOD, 16'hFFFF);
		write_reg(CFG_HIT_COST, 16'hFFFF);
		write_reg(CFG_MISS_COST, 16'd0);
		@(negedge clk);
		push_ref(1, 0);
		push_ref(2, 0);
		push_ref(1, 0);
		push_ref(3, 0);
		push_ref(2, 1);
		drain();

		// frame count lowered in the middle of a run
		write_reg(CFG_FRAMES_IN_USE, 16'd4);
		write_reg(CFG_SHIFT_PERIOD, 16'd30);
		write_reg(CFG_HIT_COST, 16'd7);
		write_reg(CFG_MISS_COST, 16'd13);
		@(negedge clk);
		push_ref(10, 0);
		push_ref(11, 0);
		push_ref(12, 0);
		push_ref(13, 0);
		push_ref(10, 0);
		drain();
		write_reg(CFG_FRAMES_IN_USE, 16'd2);
		@(negedge clk);
		push_ref(13, 0);
		push_ref(20, 0);
		push_ref(12, 0);
		push_ref(10, 0);
		push_ref(13, 1);
		drain();

		// frame count above the maximum acts as the maximum
		write_reg(CFG_FRAMES_IN_USE, 16'hFFC8);
		write_reg(CFG_SHIFT_PERIOD, 16'd1);
		write_reg(CFG_HIT_COST, 16'h0155);
		write_reg(CFG_MISS_COST, 16'hAA80);
		@(negedge clk);
		push_ref(64, 0);
		push_ref(63, 1);
		drain();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin
					frames = $urandom_range(2, 8);
					period = $urandom_range(1, 200);
					hit = $urandom_range(0, 255);
					miss = $urandom_range(0, 255);
					count = 120;
				end
				1: begin
					frames = 1;
					period = 8;
					hit = 10;
					miss = 50;
					count = 100;
				end
				2: begin
					// long run that drives the elapsed time into saturation
					frames = $urandom_range(8, 40);
					period = 0;
					hit = 255;
					miss = 255;
					count = 560;
				end
				3: begin
					frames = MAX_FRAMES_DEF;
					period = 65535;
					hit = 0;
					miss = 0;
					count = 100;
				end
				4: begin
					frames = 255;
					period = $urandom_range(0, 65535);
					hit = $urandom_range(0, 255);
					miss = $urandom_range(0, 255);
					count = 90;
				end
				default: begin
					frames = $urandom_range(1, 128);
					period = $urandom_range(1, 600);
					hit = $urandom_range(0, 255);
					miss = $urandom_range(0, 255);
					count = 80;
				end
			endcase
			write_reg(CFG_FRAMES_IN_USE, CFG_DATA_W'(frames));
			write_reg(CFG_SHIFT_PERIOD, CFG_DATA_W'(period));
			write_reg(CFG_HIT_COST, CFG_DATA_W'(hit));
			write_reg(CFG_MISS_COST, CFG_DATA_W'(miss));
			cap = (frames == 0) ? 1 : ((frames > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : frames);
			window = cap + $urandom_range(1, 4);
			base = $urandom_range(0, 127);
			@(negedge clk);
			for (int k = 0; k < count; k++) begin
				// mostly a working set slightly larger than the frames, some noise
				if ($urandom_range(0, 49) == 0) base = $urandom_range(0, 127);
				if ($urandom_range(0, 7) == 0 || window >= PAGE_COUNT_DEF)
					page = $urandom_range(0, 127);
				else
					page = (base + $urandom_range(0, window - 1)) % PAGE_COUNT_DEF;
				last = (k == count - 1) || (p != 2 && $urandom_range(0, 39) == 0);
				push_ref(page, last);
			end
			drain();
		end

		repeat (MAX_FRAMES_DEF + 150) @(posedge clk);
		if (mismatches == 0 && predicted_lookups.size() == 0) begin
			$display("aging_page_replacement_top_tb passed");
		end else begin
			$display("aging_page_replacement_top_tb failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/apr_pkg.sv
hw/rtl/apr_ages.sv
hw/rtl/aging_page_replacement_top.sv
sim/aging_page_replacement_top_tb.sv
